@@ design/ctsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsc_pkg: shared types and constants of the clock time setting controller
// Beat payloads, calendar field record, command and key codes, field limits.
// ----------------------------------------------------------------------------
package ctsc_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_KEY  = 2'd1;
    localparam logic [1:0] CMD_RTC  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // key codes
    localparam logic [2:0] KEY_MODE   = 3'd1;
    localparam logic [2:0] KEY_SELECT = 3'd2;
    localparam logic [2:0] KEY_UP     = 3'd3;
    localparam logic [2:0] KEY_DOWN   = 3'd4;

    // field select codes
    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;

    // field limits
    localparam logic [4:0] LEN_LONG  = 5'd31;
    localparam logic [4:0] LEN_SHORT = 5'd30;
    localparam logic [4:0] LEN_LEAP  = 5'd29;
    localparam logic [4:0] LEN_FEB   = 5'd28;
    localparam logic [4:0] LEN_NONE  = 5'd0;

    localparam logic [15:0] BLINK_RESET = 16'd500;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [6:0] day;     // may climb past 31 while the month is invalid
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_calendar;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] key_number;
        logic [6:0] rtc_year;
        logic [3:0] rtc_month;
        logic [4:0] rtc_day;
        logic [4:0] rtc_hour;
        logic [5:0] rtc_minute;
        logic [5:0] rtc_second;
    } t_in_item;

    typedef struct packed {
        logic       set_mode;
        logic [2:0] selected_field;
        logic       blink_on;
        logic       write_rtc;
        logic [6:0] out_year;
        logic [3:0] out_month;
        logic [4:0] out_day;
        logic [4:0] out_hour;
        logic [5:0] out_minute;
        logic [5:0] out_second;
    } t_out_item;

endpackage

@@ design/ctsc_if.sv @@
// ----------------------------------------------------------------------------
// ctsc_if: valid/ready channels of the clock time setting controller
// One interface for the input beat and one for the result beat.
// ----------------------------------------------------------------------------
interface ctsc_in_if import ctsc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ctsc_out_if import ctsc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/ctsc_field_step.sv @@
// ----------------------------------------------------------------------------
// ctsc_field_step: one up or down step of the selected calendar field
// Steps the selected field, then wraps the fields at their limits; the day saturates while the month is invalid.
// ----------------------------------------------------------------------------
module ctsc_field_step import ctsc_pkg::*; (
    input  t_calendar  i_cal,
    input  logic [2:0] i_sel,
    input  logic       i_down,
    output t_calendar  o_cal
);

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = LEN_SHORT;
            4'd2:                                       len = leap ? LEN_LEAP : LEN_FEB;
            default:                                    len = LEN_NONE;
        endcase
        return len;
    endfunction

    logic signed [8:0] w_step;
    logic signed [8:0] w_year;
    logic signed [8:0] w_month;
    logic signed [8:0] w_day;
    logic signed [8:0] w_hour;
    logic signed [8:0] w_minute;
    logic signed [8:0] w_second;
    logic signed [8:0] w_len_s;
    logic        [4:0] w_len;

    always_comb begin
        w_step = i_down ? -9'sd1 : 9'sd1;

        w_year   = $signed({2'b00, i_cal.year})   + ((i_sel == FLD_YEAR)   ? w_step : 9'sd0);
        w_month  = $signed({5'b0, i_cal.month})   + ((i_sel == FLD_MONTH)  ? w_step : 9'sd0);
        w_day    = $signed({2'b00, i_cal.day})    + ((i_sel == FLD_DAY)    ? w_step : 9'sd0);
        w_hour   = $signed({4'b0, i_cal.hour})    + ((i_sel == FLD_HOUR)   ? w_step : 9'sd0);
        w_minute = $signed({3'b0, i_cal.minute})  + ((i_sel == FLD_MINUTE) ? w_step : 9'sd0);
        w_second = $signed({3'b0, i_cal.second})  + ((i_sel == FLD_SECOND) ? w_step : 9'sd0);

        if (w_year > 9'sd99) w_year = 9'sd0;
        if (w_year < 9'sd0)  w_year = 9'sd99;

        if (w_month > 9'sd12)           w_month = 9'sd1;
        if (i_down && w_month < 9'sd1)  w_month = 9'sd12;

        // leap year check uses the year after its own wrap
        w_len   = month_length(w_month[3:0], w_year[1:0] == 2'b00);
        w_len_s = $signed({4'b0, w_len});

        if (w_len != LEN_NONE) begin
            if (i_down && w_day < 9'sd1) w_day = w_len_s;
            if (w_day > w_len_s)         w_day = 9'sd1;
        end else begin
            // no valid month: saturate only
            if (w_day < 9'sd0)   w_day = 9'sd0;
            if (w_day > 9'sd127) w_day = 9'sd127;
        end

        if (w_hour > 9'sd23)   w_hour = 9'sd0;
        if (w_hour < 9'sd0)    w_hour = 9'sd23;
        if (w_minute > 9'sd59) w_minute = 9'sd0;
        if (w_minute < 9'sd0)  w_minute = 9'sd59;
        if (w_second > 9'sd59) w_second = 9'sd0;
        if (w_second < 9'sd0)  w_second = 9'sd59;

        o_cal.year   = w_year[6:0];
        o_cal.month  = w_month[3:0];
        o_cal.day    = w_day[6:0];
        o_cal.hour   = w_hour[4:0];
        o_cal.minute = w_minute[5:0];
        o_cal.second = w_second[5:0];
    end

endmodule

@@ design/clock_time_setting_controller.sv @@
// ----------------------------------------------------------------------------
// clock_time_setting_controller: key-driven time setting for a calendar clock
// Path: an accepted beat passes the input register, then the result register.
// Throughput: one beat per cycle while the result channel is not stalled, set by the single next-state stage.
// Reset: sync active low; show mode, year 0, month 1, day 1, rest 0, blink 500.
// ----------------------------------------------------------------------------
module clock_time_setting_controller import ctsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ctsc_in_if.sink     i_in,
    ctsc_out_if.source  o_out
);

    // Two register stages: an input register holding the accepted beat and a
    // result register. The controller state sits beside the result register
    // and moves with it, so a beat waiting in the input register always sees
    // the state left by the beat ahead of it.

    // input stage
    logic       r_in_valid;
    t_in_item   r_in;

    // result stage
    logic       r_out_valid;
    t_out_item  r_out;

    // controller state
    logic        r_mode;
    logic [2:0]  r_sel;
    logic        r_blink;
    logic [15:0] r_tick;
    t_calendar   r_cal;
    logic [15:0] r_blink_half;

    logic        n_mode;
    logic [2:0]  n_sel;
    logic        n_blink;
    logic [15:0] n_tick;
    t_calendar   n_cal;
    t_out_item   n_out;

    logic        w_advance;
    logic [15:0] w_tick_inc;
    t_calendar   w_stepped;

    // advance when the result stage is empty or being drained this cycle
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // one shared step unit; direction comes from the key
    ctsc_field_step u_step (
        .i_cal  (r_cal),
        .i_sel  (r_sel),
        .i_down (r_in.key_number == KEY_DOWN),
        .o_cal  (w_stepped)
    );

    assign w_tick_inc = r_tick + 16'd1;

    // next state of the controller for the beat in the input register
    always_comb begin
        n_mode  = r_mode;
        n_sel   = r_sel;
        n_blink = r_blink;
        n_tick  = r_tick;
        n_cal   = r_cal;
        n_out.write_rtc = 1'b0;

        case (r_in.cmd)
            CMD_TICK: begin
                // clear and toggle once the half period is reached
                if (w_tick_inc >= r_blink_half) begin
                    n_tick  = 16'd0;
                    n_blink = !r_blink;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            CMD_KEY: begin
                if (r_in.key_number == KEY_MODE) begin
                    if (!r_mode) begin
                        n_mode = 1'b1;
                        n_sel  = FLD_YEAR;
                    end else begin
                        // leaving set mode: pulse the write request
                        n_mode          = 1'b0;
                        n_out.write_rtc = 1'b1;
                    end
                end else if (r_mode) begin
                    case (r_in.key_number)
                        KEY_SELECT: n_sel = (r_sel == FLD_SECOND) ? FLD_YEAR : r_sel + 3'd1;
                        KEY_UP:     n_cal = w_stepped;
                        KEY_DOWN:   n_cal = w_stepped;
                        default:    ;
                    endcase
                end
            end
            CMD_RTC: begin
                // readings load the fields in show mode only
                if (!r_mode) begin
                    n_cal.year   = r_in.rtc_year;
                    n_cal.month  = r_in.rtc_month;
                    n_cal.day    = {2'b00, r_in.rtc_day};
                    n_cal.hour   = r_in.rtc_hour;
                    n_cal.minute = r_in.rtc_minute;
                    n_cal.second = r_in.rtc_second;
                end
            end
            CMD_NONE: ;
            default:  ;
        endcase

        // result shows the state after the beat
        n_out.set_mode       = n_mode;
        n_out.selected_field = n_sel;
        n_out.blink_on       = n_blink;
        n_out.out_year       = n_cal.year;
        n_out.out_month      = n_cal.month;
        n_out.out_day        = n_cal.day[4:0];
        n_out.out_hour       = n_cal.hour;
        n_out.out_minute     = n_cal.minute;
        n_out.out_second     = n_cal.second;
    end

    // input register: take a beat whenever ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // result register: hold while stalled, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // controller state: advance with the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_sel        <= FLD_YEAR;
            r_blink      <= 1'b0;
            r_tick       <= 16'd0;
            r_cal.year   <= 7'd0;
            r_cal.month  <= 4'd1;
            r_cal.day    <= 7'd1;
            r_cal.hour   <= 5'd0;
            r_cal.minute <= 6'd0;
            r_cal.second <= 6'd0;
        end else if (w_advance) begin
            r_mode  <= n_mode;
            r_sel   <= n_sel;
            r_blink <= n_blink;
            r_tick  <= n_tick;
            r_cal   <= n_cal;
        end
    end

    // blink half period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_half <= BLINK_RESET;
        end else if (i_cfg_we) begin
            r_blink_half <= i_cfg_wdata;
        end
    end

`ifndef ASSERT_OFF
    // a write request only comes with the return to show mode
    a_write_in_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.write_rtc) |-> !r_out.set_mode)
        else $error("write_rtc raised while still in set mode");

    // the selection never leaves the six fields
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel <= FLD_SECOND)
        else $error("field select out of range");

    // calendar state only moves when a beat advances
    a_cal_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_cal))
        else $error("calendar changed without an advancing beat");

    // input stalls only behind a full, stalled pipeline
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: clock time setting controller
// Drives tick, key and RTC beats through the valid/ready input channel with
// bursty gaps, stalls the result channel on its own pattern, and checks each
// result beat against an in-bench prediction of the mode, selection, blink
// and calendar state. Blink period is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
    import ctsc_pkg::*;

    localparam int RESET_CYCLES     = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT      = 4000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int DRAIN_CYCLES     = 4;
    localparam int PHASE_BEATS      = 320;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    ctsc_in_if  in_if ();
    ctsc_out_if out_if ();

    clock_time_setting_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bookkeeping shared by the stimulus, driver and checker
    // ------------------------------------------------------------------------
    t_in_item  pending_beats[$];     // beats waiting for the driver
    t_out_item expected_readouts[$]; // predicted result beats, oldest first
    int        beats_pushed   = 0;
    int        beats_taken    = 0;
    int        fail_count     = 0;
    int        idle_cycles    = 0;
    int        hold_requests  = 0;
    logic      in_fire_q      = 1'b0;

    // ------------------------------------------------------------------------
    // Predicted state of the controller
    // ------------------------------------------------------------------------
    logic        set_mode_r;
    logic [2:0]  field_r;
    logic        blink_r;
    logic [15:0] tick_r;
    logic [15:0] blink_half_r;
    t_calendar   cal_r;

    function automatic void clear_clock_state();
        set_mode_r   = 1'b0;
        field_r      = FLD_YEAR;
        blink_r      = 1'b0;
        tick_r       = '0;
        blink_half_r = BLINK_RESET;
        cal_r        = '{year: 7'd0, month: 4'd1, day: 7'd1, hour: 5'd0,
                         minute: 6'd0, second: 6'd0};
    endfunction

    function automatic int days_in_month(int month, int year);
        case (month)
            1, 3, 5, 7, 8, 10, 12: return int'(LEN_LONG);
            4, 6, 9, 11:           return int'(LEN_SHORT);
            2:                     return (year % 4 == 0) ? int'(LEN_LEAP) : int'(LEN_FEB);
            default:               return int'(LEN_NONE);
        endcase
    endfunction

    // Step the selected field, then wrap every field at its limits. The day
    // only wraps against a valid month; otherwise it saturates at 0..127.
    function automatic void step_selected(int delta);
        int y, m, d, h, mi, s, len;
        y  = int'(cal_r.year);
        m  = int'(cal_r.month);
        d  = int'(cal_r.day);
        h  = int'(cal_r.hour);
        mi = int'(cal_r.minute);
        s  = int'(cal_r.second);
        case (field_r)
            FLD_YEAR:   y  += delta;
            FLD_MONTH:  m  += delta;
            FLD_DAY:    d  += delta;
            FLD_HOUR:   h  += delta;
            FLD_MINUTE: mi += delta;
            FLD_SECOND: s  += delta;
            default: ;
        endcase
        if (y > 99) y = 0;
        if (y < 0) y = 99;
        if (m > 12) m = 1;
        if (delta < 0 && m < 1) m = 12;
        len = days_in_month(m, y);
        if (len > 0) begin
            if (delta < 0 && d < 1) d = len;
            if (d > len) d = 1;
        end else begin
            if (d < 0) d = 0;
            if (d > 127) d = 127;
        end
        if (h > 23) h = 0;
        if (h < 0) h = 23;
        if (mi > 59) mi = 0;
        if (mi < 0) mi = 59;
        if (s > 59) s = 0;
        if (s < 0) s = 59;
        cal_r.year   = y[6:0];
        cal_r.month  = m[3:0];
        cal_r.day    = d[6:0];
        cal_r.hour   = h[4:0];
        cal_r.minute = mi[5:0];
        cal_r.second = s[5:0];
    endfunction

    // Advance the predicted state by one accepted beat and return the readout.
    function automatic t_out_item apply_beat(t_in_item b);
        t_out_item r;
        logic      wr;
        wr = 1'b0;
        case (b.cmd)
            CMD_TICK: begin
                tick_r = tick_r + 16'd1;
                if (tick_r >= blink_half_r) begin
                    tick_r  = '0;
                    blink_r = ~blink_r;
                end
            end
            CMD_KEY: begin
                if (b.key_number == KEY_MODE) begin
                    if (!set_mode_r) begin
                        set_mode_r = 1'b1;
                        field_r    = FLD_YEAR;
                    end else begin
                        set_mode_r = 1'b0;
                        wr         = 1'b1;
                    end
                end else if (set_mode_r) begin
                    if (b.key_number == KEY_SELECT)
                        field_r = (field_r == FLD_SECOND) ? FLD_YEAR : field_r + 3'd1;
                    else if (b.key_number == KEY_UP)
                        step_selected(1);
                    else if (b.key_number == KEY_DOWN)
                        step_selected(-1);
                end
            end
            CMD_RTC: begin
                if (!set_mode_r) begin
                    cal_r.year   = b.rtc_year;
                    cal_r.month  = b.rtc_month;
                    cal_r.day    = {2'b00, b.rtc_day};
                    cal_r.hour   = b.rtc_hour;
                    cal_r.minute = b.rtc_minute;
                    cal_r.second = b.rtc_second;
                end
            end
            default: ;
        endcase
        r.set_mode       = set_mode_r;
        r.selected_field = field_r;
        r.blink_on       = blink_r;
        r.write_rtc      = wr;
        r.out_year       = cal_r.year;
        r.out_month      = cal_r.month;
        r.out_day        = cal_r.day[4:0];
        r.out_hour       = cal_r.hour;
        r.out_minute     = cal_r.minute;
        r.out_second     = cal_r.second;
        return r;
    endfunction

    function automatic string readout_text(t_out_item r);
        return $sformatf("mode=%0d sel=%0d blink=%0d wr=%0d %0d-%0d-%0d %0d:%0d:%0d",
                         r.set_mode, r.selected_field, r.blink_on, r.write_rtc,
                         r.out_year, r.out_month, r.out_day,
                         r.out_hour, r.out_minute, r.out_second);
    endfunction

    function automatic string differing_fields(t_out_item want, t_out_item got);
        string s;
        s = "";
        if (want.set_mode       !== got.set_mode)       s = {s, " set_mode"};
        if (want.selected_field !== got.selected_field) s = {s, " selected_field"};
        if (want.blink_on       !== got.blink_on)       s = {s, " blink_on"};
        if (want.write_rtc      !== got.write_rtc)      s = {s, " write_rtc"};
        if (want.out_year       !== got.out_year)       s = {s, " out_year"};
        if (want.out_month      !== got.out_month)      s = {s, " out_month"};
        if (want.out_day        !== got.out_day)        s = {s, " out_day"};
        if (want.out_hour       !== got.out_hour)       s = {s, " out_hour"};
        if (want.out_minute     !== got.out_minute)     s = {s, " out_minute"};
        if (want.out_second     !== got.out_second)     s = {s, " out_second"};
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Checker: sample both channels at the rising edge. Check the result
    // beat first, then predict the input beat taken on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        string     diff;
        if (!i_rst_n) begin
            clear_clock_state();
            in_fire_q <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_readouts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOWN_MISMATCHES)
                        $display("[%0t] result beat with nothing expected: %s",
                                 $realtime, readout_text(out_if.data));
                end else begin
                    want = expected_readouts.pop_front();
                    diff = differing_fields(want, out_if.data);
                    if (diff != "") begin
                        fail_count++;
                        if (fail_count <= SHOWN_MISMATCHES)
                            $display("[%0t] mismatch in%s: expected %s, got %s", $realtime,
                                     diff, readout_text(want), readout_text(out_if.data));
                    end
                end
            end
            if (i_cfg_we)
                blink_half_r = i_cfg_wdata;
            if (in_if.valid && in_if.ready) begin
                expected_readouts.push_back(apply_beat(in_if.data));
                beats_taken++;
            end
            in_fire_q <= in_if.valid && in_if.ready;

            // Watchdog: end the run when neither channel moves for too long.
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] no beat moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("** clock_time_setting_controller: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change the input channel at the falling edge. Hold a beat
    // until it is taken, then offer the next one in bursts with gaps.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fire_q) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                in_if.data  <= pending_beats.pop_front();
                in_if.valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // pick the next burst; mostly short gaps, now and then a long one
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(0, 4);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a rotating ready pattern, reloaded when its random run
    // length is used up; on request, hold ready low for a long stretch.
    // ------------------------------------------------------------------------
    int          holds_done = 0;
    int          hold_left  = 0;
    int          pat_left   = 0;
    logic [15:0] ready_pat  = '1;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (holds_done < hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : (16'($urandom) | 16'h0001);
                    pat_left  = $urandom_range(16, 96);
                end
                out_if.ready <= ready_pat[0];
                ready_pat = {ready_pat[0], ready_pat[15:1]};
                pat_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item random_beat();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    task automatic push_beat(t_in_item b);
        pending_beats.push_back(b);
        beats_pushed++;
    endtask

    // Unused fields of ticks and keys carry random bits; the block ignores them.
    task automatic push_cmd(logic [1:0] cmd, logic [2:0] key);
        t_in_item b;
        b            = random_beat();
        b.cmd        = cmd;
        b.key_number = key;
        push_beat(b);
    endtask

    task automatic push_rtc(logic [6:0] y, logic [3:0] m, logic [4:0] d,
                            logic [4:0] h, logic [5:0] mi, logic [5:0] s);
        t_in_item b;
        b            = random_beat();
        b.cmd        = CMD_RTC;
        b.rtc_year   = y;
        b.rtc_month  = m;
        b.rtc_day    = d;
        b.rtc_hour   = h;
        b.rtc_minute = mi;
        b.rtc_second = s;
        push_beat(b);
    endtask

    // Mostly a plausible reading, sometimes any bit pattern at all.
    task automatic push_random_rtc();
        if ($urandom_range(0, 3) != 0)
            push_rtc(7'($urandom_range(0, 99)), 4'($urandom_range(1, 12)),
                     5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                     6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
        else
            push_rtc(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                     5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    endtask

    // Any key code, or the unused command.
    task automatic push_noise();
        if ($urandom_range(0, 2) == 0)
            push_cmd(CMD_NONE, 3'($urandom_range(0, 7)));
        else
            push_cmd(CMD_KEY, 3'($urandom_range(0, 7)));
    endtask

    // Mostly complete set-mode sessions (enter, edit, leave) with random
    // content, mixed with show-mode ticks, readings and stray keys.
    task automatic push_random_mix(int n);
        int made, r, k;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                push_cmd(CMD_KEY, KEY_MODE);
                made++;
                k = $urandom_range(1, 14);
                repeat (k) begin
                    r = $urandom_range(0, 99);
                    if (r < 30)      push_cmd(CMD_KEY, KEY_SELECT);
                    else if (r < 52) push_cmd(CMD_KEY, KEY_UP);
                    else if (r < 74) push_cmd(CMD_KEY, KEY_DOWN);
                    else if (r < 88) push_cmd(CMD_TICK, 3'($urandom_range(0, 7)));
                    else if (r < 94) push_random_rtc();
                    else             push_noise();
                    made++;
                end
                push_cmd(CMD_KEY, KEY_MODE);
                made++;
            end else begin
                k = $urandom_range(1, 8);
                repeat (k) begin
                    r = $urandom_range(0, 99);
                    if (r < 50)      push_cmd(CMD_TICK, 3'($urandom_range(0, 7)));
                    else if (r < 80) push_random_rtc();
                    else             push_noise();
                    made++;
                end
            end
        end
    endtask

    task automatic write_blink_half(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stop offering beats until every queued beat is taken and every result
    // has come back, then let the pipeline settle.
    task automatic wait_quiet();
        while (beats_taken != beats_pushed || expected_readouts.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] setting;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the shortest blink period: one toggle per tick.
        write_blink_half(16'd1);
        push_cmd(CMD_TICK, KEY_MODE);
        push_cmd(CMD_KEY, KEY_SELECT);          // edit keys ignored in show mode
        push_cmd(CMD_KEY, 3'd0);                // unused key codes
        push_cmd(CMD_KEY, 3'd7);
        push_cmd(CMD_NONE, KEY_MODE);           // unused command
        push_rtc(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
        push_cmd(CMD_KEY, KEY_MODE);            // enter set mode on the year
        push_rtc(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);  // ignored in set mode
        push_cmd(CMD_KEY, KEY_UP);              // every out-of-range field wraps
        push_cmd(CMD_KEY, KEY_DOWN);            // year below zero
        push_cmd(CMD_KEY, KEY_MODE);            // leave: write pulse
        push_rtc(7'd96, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59);
        push_cmd(CMD_KEY, KEY_MODE);
        push_cmd(CMD_KEY, KEY_SELECT);
        push_cmd(CMD_KEY, KEY_SELECT);          // day of a leap February
        push_cmd(CMD_KEY, KEY_UP);
        push_cmd(CMD_KEY, KEY_DOWN);
        push_cmd(CMD_KEY, KEY_SELECT);
        push_cmd(CMD_KEY, KEY_SELECT);
        push_cmd(CMD_KEY, KEY_SELECT);          // second
        push_cmd(CMD_KEY, KEY_UP);
        push_cmd(CMD_KEY, KEY_SELECT);          // selection wraps to the year
        push_cmd(CMD_KEY, KEY_MODE);
        push_rtc(7'd0, 4'd0, 5'd31, 5'd0, 6'd0, 6'd0);  // invalid month
        push_cmd(CMD_KEY, KEY_MODE);
        push_cmd(CMD_KEY, KEY_SELECT);
        push_cmd(CMD_KEY, KEY_SELECT);
        push_cmd(CMD_KEY, KEY_UP);              // day climbs past 31 unchecked
        push_cmd(CMD_KEY, KEY_DOWN);            // decrement pulls month to 12
        push_cmd(CMD_KEY, KEY_MODE);
        wait_quiet();

        // Random phases, each with its own blink period; one of them runs
        // under a long receiver hold so the block backs up into its input.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       setting = 16'hFFFF;
                1:       setting = 16'd3;
                2:       setting = 16'($urandom_range(1, 8));
                3:       setting = 16'd1;
                4:       setting = 16'($urandom_range(9, 600));
                default: setting = 16'($urandom_range(1, 65535));
            endcase
            write_blink_half(setting);
            if (p == 2)
                hold_requests++;
            push_random_mix(PHASE_BEATS);
            wait_quiet();
        end

        if (fail_count == 0)
            $display("** clock_time_setting_controller: PASSED **");
        else
            $display("** clock_time_setting_controller: FAILED **");
        $finish;
    end

endmodule
